// ----- hdl/u8dec_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, codes and helper functions shared by the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned UnitWidth  = 16;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned PendWidth  = 3;
   localparam int unsigned ShiftWidth = 5;
   localparam int unsigned LenWidth   = 3;
   // wide enough for a one-byte payload shifted by the largest gather offset
   localparam int unsigned GatherWidth = 38;

   localparam logic [UnitWidth-1:0]  ReplacementReset = 16'h003F;
   localparam logic [CountWidth-1:0] CountMax         = 16'hFFFF;
   localparam logic [1:0]            ContTag          = 2'b10;
   localparam logic [5:0]            ContMask         = 6'h3F;

   typedef enum logic [1:0] {
      END_NONE  = 2'd0,
      END_ZERO  = 2'd1,
      END_BAD   = 2'd2,
      END_TRUNC = 2'd3
   } end_status_type;

   typedef struct packed {
      logic [UnitWidth-1:0]  acc;
      logic                  wide;
      logic [PendWidth-1:0]  pend;
      logic [CountWidth-1:0] count;
      logic                  skip;
   } dec_state_type;

   typedef struct packed {
      logic                  char_valid;
      logic [UnitWidth-1:0]  code_unit;
      logic [CountWidth-1:0] char_count;
      logic                  string_done;
      end_status_type        end_status;
   } dec_result_type;

   // number of leading one bits of a byte, 0 to 7
   function automatic logic [LenWidth-1:0] lead_len(input logic [ByteWidth-1:0] b);
      logic [LenWidth-1:0] n;
      case (b) inside
         8'b0???????: n = 3'd0;
         8'b10??????: n = 3'd1;
         8'b110?????: n = 3'd2;
         8'b1110????: n = 3'd3;
         8'b11110???: n = 3'd4;
         8'b111110??: n = 3'd5;
         8'b1111110?: n = 3'd6;
         default:     n = 3'd7;
      endcase
      return n;
   endfunction

endpackage

// ----- hdl/u8dec_if.sv -----
// ----------------------------------------------------------------------------
// u8dec_if
// Valid/ready channels of the decoder: byte requests, results, register writes.
// ----------------------------------------------------------------------------
interface u8dec_req_if;
   logic                              valid;
   logic                              ready;
   logic [u8dec_pkg::ByteWidth-1:0]   in_byte;
   logic                              last_byte;

   modport source (output valid, in_byte, last_byte, input ready);
   modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface u8dec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              char_valid;
   logic [u8dec_pkg::UnitWidth-1:0]   code_unit;
   logic [u8dec_pkg::CountWidth-1:0]  char_count;
   logic                              string_done;
   logic [1:0]                        end_status;

   modport source (output valid, char_valid, code_unit, char_count, string_done,
                   end_status, input ready);
   modport sink   (input valid, char_valid, code_unit, char_count, string_done,
                   end_status, output ready);
endinterface

interface u8dec_csr_if;
   logic                              valid;
   logic                              ready;
   logic [u8dec_pkg::UnitWidth-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/u8dec_step.sv -----
// ----------------------------------------------------------------------------
// u8dec_step
// Per-byte decode: next string state and the result for one byte.
// ----------------------------------------------------------------------------
module u8dec_step (
   input  u8dec_pkg::dec_state_type            state_ff,
   input  logic [u8dec_pkg::ByteWidth-1:0]     in_byte,
   input  logic                                last_byte,
   input  logic [u8dec_pkg::UnitWidth-1:0]     repl_char,
   output u8dec_pkg::dec_state_type            state_in,
   output u8dec_pkg::dec_result_type           result
);

   logic [u8dec_pkg::LenWidth-1:0]    n;
   logic [u8dec_pkg::ByteWidth-1:0]   payload;
   logic [u8dec_pkg::ShiftWidth-1:0]  shift;
   logic [u8dec_pkg::GatherWidth-1:0] shifted;
   logic                              do_gather;
   logic                              emit;
   logic                              done;
   logic [u8dec_pkg::UnitWidth-1:0]   unit;
   u8dec_pkg::end_status_type         status;
   u8dec_pkg::dec_state_type          st;

   assign n       = u8dec_pkg::lead_len(in_byte);
   assign shifted = u8dec_pkg::GatherWidth'(payload) << shift;

   always_comb begin
      st        = state_ff;
      payload   = '0;
      shift     = '0;
      do_gather = 1'b0;
      emit      = 1'b0;
      done      = 1'b0;
      unit      = '0;
      status    = u8dec_pkg::END_NONE;

      if (state_ff.skip) begin
         // drop the byte
      end else if (state_ff.pend != '0) begin
         if (in_byte[7:6] != u8dec_pkg::ContTag) begin
            done   = 1'b1;
            status = u8dec_pkg::END_BAD;
         end else begin
            payload   = {2'b00, in_byte[5:0] & u8dec_pkg::ContMask};
            shift     = u8dec_pkg::ShiftWidth'(state_ff.pend - 3'd1)
                        * u8dec_pkg::ShiftWidth'(6);
            do_gather = 1'b1;
            st.pend   = state_ff.pend - 3'd1;
            if (st.pend == '0) begin
               emit = 1'b1;
            end else if (last_byte) begin
               done   = 1'b1;
               status = u8dec_pkg::END_TRUNC;
            end
         end
      end else if (n == 3'd0) begin
         st.acc  = u8dec_pkg::UnitWidth'(in_byte);
         st.wide = 1'b0;
         emit    = 1'b1;
      end else if (n >= 3'd2 && n <= 3'd6) begin
         st.acc    = '0;
         st.wide   = 1'b0;
         payload   = in_byte & (8'hFF >> (n + 3'd1));
         shift     = u8dec_pkg::ShiftWidth'(n - 3'd1) * u8dec_pkg::ShiftWidth'(6);
         do_gather = 1'b1;
         st.pend   = n - 3'd1;
         if (last_byte) begin
            done   = 1'b1;
            status = u8dec_pkg::END_TRUNC;
         end
      end

      // merge the shifted payload; anything above 16 bits flags the value
      if (do_gather) begin
         if (shifted[u8dec_pkg::GatherWidth-1:u8dec_pkg::UnitWidth] != '0) begin
            st.wide = 1'b1;
         end
         st.acc = st.acc | shifted[u8dec_pkg::UnitWidth-1:0];
      end

      if (emit) begin
         unit = st.wide ? repl_char : st.acc;
         if (st.count != u8dec_pkg::CountMax) begin
            st.count = st.count + 16'd1;
         end
         st.acc  = '0;
         st.wide = 1'b0;
         if (unit == '0) begin
            done   = 1'b1;
            status = u8dec_pkg::END_ZERO;
         end
      end

      if (last_byte) begin
         done = 1'b1;
      end

      result.char_valid  = emit;
      result.code_unit   = unit;
      result.char_count  = st.count;
      result.string_done = done;
      result.end_status  = status;

      state_in = st;
      if (last_byte) begin
         state_in = '0;
      end else if (done) begin
         state_in.skip = 1'b1;
         state_in.pend = '0;
         state_in.acc  = '0;
         state_in.wide = 1'b0;
      end
   end

endmodule

// ----- hdl/utf8_to_ucs2_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Byte-serial UTF-8 decoder producing 16-bit code units with string status.
// ----------------------------------------------------------------------------
// Usage:
//   req: one UTF-8 byte per transfer, last_byte set on the final byte of a
//        buffer. The next byte after it starts a new string.
//   rsp: exactly one result per request byte, in order: an optional code
//        unit, the running character count and the end status.
//   csr: write-only replacement character (reset 0x003F), ready always high;
//        write it only while no byte is in flight.
// Path: a req transfer reaches rsp valid via the input register, then the
//   result register. Throughput: one byte per cycle unless rsp stalls; the
//   whole decode of a byte is one shallow pass between the two registers.
// Stall: while rsp is held off, the result register holds and the input
//   register fills; req.ready drops only when both are full, so no byte is
//   lost and upstream resumes as soon as rsp takes a transfer.
// Reset: synchronous, clears both pipeline valids, all string state and
//   sets the replacement character back to '?'.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder (
   input logic       clock,
   input logic       reset,
   u8dec_req_if.sink   req,
   u8dec_rsp_if.source rsp,
   u8dec_csr_if.sink   csr
);

   // input register
   logic                              in_valid_ff;
   logic [u8dec_pkg::ByteWidth-1:0]   in_byte_ff;
   logic                              in_last_ff;

   // result register
   logic                              out_valid_ff;
   u8dec_pkg::dec_result_type         out_ff;
   u8dec_pkg::dec_result_type         out_in;

   // string state and the configured replacement character
   u8dec_pkg::dec_state_type          state_ff;
   u8dec_pkg::dec_state_type          state_in;
   logic [u8dec_pkg::UnitWidth-1:0]   repl_ff;

   logic advance;
   logic take;

   // result stage moves when it is empty or its transfer completes
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign csr.ready = 1'b1;

   u8dec_step u_step (
      .state_ff  (state_ff),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .repl_char (repl_ff),
      .state_in  (state_in),
      .result    (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         repl_ff      <= u8dec_pkg::ReplacementReset;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            // advance string state only when a byte is actually decoded
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
         if (csr.valid) begin
            repl_ff <= csr.data;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.last_byte;
      end
      if (advance && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.char_valid  = out_ff.char_valid;
   assign rsp.code_unit   = out_ff.code_unit;
   assign rsp.char_count  = out_ff.char_count;
   assign rsp.string_done = out_ff.string_done;
   assign rsp.end_status  = out_ff.end_status;

endmodule

// ----- hdl/u8dec_checker.sv -----
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level assertions for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8dec_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_char_valid,
   input logic [u8dec_pkg::UnitWidth-1:0]    rsp_code_unit,
   input logic [u8dec_pkg::CountWidth-1:0]   rsp_char_count,
   input logic                               rsp_string_done,
   input logic [1:0]                         rsp_end_status
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit)
         && $stable(rsp_char_count) && $stable(rsp_end_status))
      else $error("stalled result changed");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_status != u8dec_pkg::END_NONE |-> rsp_string_done)
      else $error("end status without string end");

   a_zero_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_status == u8dec_pkg::END_ZERO
         |-> rsp_char_valid && rsp_code_unit == '0)
      else $error("zero status without zero char");

   a_error_nochar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_end_status == u8dec_pkg::END_BAD
         || rsp_end_status == u8dec_pkg::END_TRUNC) |-> !rsp_char_valid)
      else $error("char emitted with error status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind utf8_to_ucs2_decoder u8dec_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_char_valid  (rsp.char_valid),
   .rsp_code_unit   (rsp.code_unit),
   .rsp_char_count  (rsp.char_count),
   .rsp_string_done (rsp.string_done),
   .rsp_end_status  (rsp.end_status)
);
